FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the strip monitor RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never hold while out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/shdcm_pkg.sv
// ---------------------------------------------------------------------------
// shdcm_pkg
// Types and fixed constants of the strip hot/dead channel monitor.
// ---------------------------------------------------------------------------
package shdcm_pkg;

  localparam int SUM_W       = 32;   // ADC sum width
  localparam int ADC_W       = 8;
  localparam int PED_W       = 8;
  localparam int THR_W       = 8;
  localparam int OUT_CNT_W   = 24;   // reported hit count width
  localparam int D_W         = 33;   // 2s - p*n on the low-count branch
  localparam int LHS_W       = 78;   // d*d*n with n up to 2500
  localparam int SMALL_N_W   = 12;
  localparam int SMALL_N_MAX = 2500; // boundary between the two hot tests
  localparam int HOT_S_MUL   = 94;   // high-count test: 94*s > 50*p*n
  localparam int HOT_PN_MUL  = 50;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_EVEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PED_X2    = 2'd2;

  localparam logic OP_HIT   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    STATUS_NO_DATA = 2'd0,
    STATUS_DEAD    = 2'd1,
    STATUS_HOT     = 2'd2,
    STATUS_NORMAL  = 2'd3
  } status_e;

  // hot test unit response
  typedef struct packed {
    logic done;
    logic hot;
  } hot_rsp_t;

endpackage

FILE: hdl/shdcm_hot_test.sv
// ---------------------------------------------------------------------------
// shdcm_hot_test
// Exact integer hot-strip test, low-count products done bit-serially.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module shdcm_hot_test #(
  parameter int CountBits = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [CountBits-1:0]   n_i,
  input  logic [31:0]            s_i,
  input  logic [7:0]             p_i,
  output logic                   busy_o,
  output shdcm_pkg::hot_rsp_t    rsp_o
);
  import shdcm_pkg::*;

  localparam int PnW   = CountBits + PED_W;
  localparam int NExtW = (CountBits > SMALL_N_W) ? CountBits : SMALL_N_W;
  localparam int BigW  = (CountBits + 14 > 39) ? CountBits + 14 : 39;

  typedef enum logic [5:0] {
    H_IDLE  = 6'b000001,
    H_SPLIT = 6'b000010,
    H_MDD   = 6'b000100,  // d*d
    H_MN    = 6'b001000,  // (d*d)*n
    H_MSS   = 6'b010000,  // s*s
    H_CMP   = 6'b100000
  } hstate_e;

  hstate_e              state_q, state_d;
  logic                 done_q, done_d;
  logic                 hot_q, hot_d;
  logic                 big_q, big_d;
  logic [CountBits-1:0] n_q, n_d;
  logic [SUM_W-1:0]     s_q, s_d;
  logic [PnW-1:0]       pn_q, pn_d;
  logic [BigW-1:0]      s94_q, s94_d, pn50_q, pn50_d;
  logic [LHS_W-1:0]     mcand_q, mcand_d, acc_q, acc_d, lhs_q, lhs_d;
  logic [D_W-1:0]       mplier_q, mplier_d;

  logic [NExtW-1:0] n_ext;
  logic [BigW-1:0]  twos_w, pn_w, diff_w;
  logic [LHS_W-1:0] step_acc, rhs36;

  assign n_ext    = NExtW'(n_q);
  assign twos_w   = BigW'({s_q, 1'b0});
  assign pn_w     = BigW'(pn_q);
  assign diff_w   = twos_w - pn_w;
  assign step_acc = mplier_q[0] ? acc_q + mcand_q : acc_q;
  assign rhs36    = (acc_q << 5) + (acc_q << 2);

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    hot_d    = hot_q;
    big_d    = big_q;
    n_d      = n_q;
    s_d      = s_q;
    pn_d     = pn_q;
    s94_d    = s94_q;
    pn50_d   = pn50_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    lhs_d    = lhs_q;
    case (state_q)
      H_IDLE: begin
        if (start_i) begin
          n_d     = n_i;
          s_d     = s_i;
          pn_d    = PnW'(n_i) * PnW'(p_i);
          state_d = H_SPLIT;
        end
      end
      H_SPLIT: begin
        big_d = 1'b0;
        if (n_ext > NExtW'(SMALL_N_MAX)) begin
          big_d   = 1'b1;
          s94_d   = BigW'(s_q) * BigW'(HOT_S_MUL);
          pn50_d  = pn_w * BigW'(HOT_PN_MUL);
          state_d = H_CMP;
        end else if (twos_w <= pn_w) begin
          hot_d   = 1'b0;
          done_d  = 1'b1;
          state_d = H_IDLE;
        end else begin
          mcand_d  = LHS_W'(diff_w[D_W-1:0]);
          mplier_d = diff_w[D_W-1:0];
          acc_d    = '0;
          state_d  = H_MDD;
        end
      end
      H_MDD, H_MN, H_MSS: begin
        if (mplier_q != '0) begin
          acc_d    = step_acc;
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end else if (state_q == H_MDD) begin
          mcand_d  = acc_q;
          mplier_d = D_W'(n_ext[SMALL_N_W-1:0]);
          acc_d    = '0;
          state_d  = H_MN;
        end else if (state_q == H_MN) begin
          lhs_d    = acc_q;
          mcand_d  = LHS_W'(s_q);
          mplier_d = D_W'(s_q);
          acc_d    = '0;
          state_d  = H_MSS;
        end else begin
          state_d = H_CMP;
        end
      end
      H_CMP: begin
        hot_d   = big_q ? (s94_q > pn50_q) : (lhs_q > rhs36);
        done_d  = 1'b1;
        state_d = H_IDLE;
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hot_q    <= hot_d;
    big_q    <= big_d;
    n_q      <= n_d;
    s_q      <= s_d;
    pn_q     <= pn_d;
    s94_q    <= s94_d;
    pn50_q   <= pn50_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    lhs_q    <= lhs_d;
  end

  assign busy_o     = (state_q != H_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.hot  = hot_q;

  `ASSERT_IMPLY(a_start_idle, clk_i, rst_ni, start_i, state_q == H_IDLE, "start while busy")
  `ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q, "done longer than one cycle")
  `ASSERT_IMPLY(a_split_after_start, clk_i, rst_ni, state_q == H_SPLIT, $past(start_i),
                "split without start")

endmodule

FILE: hdl/strip_hot_dead_channel_monitor_core.sv
// ---------------------------------------------------------------------------
// strip_hot_dead_channel_monitor_core
// Per-strip hit/ADC accumulator with dead and hot classification queries.
// ---------------------------------------------------------------------------
// Items are handled one at a time. A hit word that changes no strip is
// taken without a memory access; one that updates a strip reads, then writes
// back, the single-port strip memory. A query of an untouched sensor or an
// out-of-range strip goes straight to the result; a query of a dead strip
// reads the memory first; any other query also runs the hot test unit: a
// scaled compare above 2500 hits, an early answer when 2s does not exceed
// p*n, else its bit-serial shift-add multiplier over d, n and s. A query
// whose result finds the output register still held by the receiver waits
// until that word leaves. After reset the block clears the strip memory one
// entry a cycle, all NumStations*NumSensors*NumStrips entries (23004 by
// default), and holds in_stall_o high until done; configuration writes are
// taken at all times and must only be issued while the block is idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module strip_hot_dead_channel_monitor_core #(
  parameter int NumStrips   = 639,
  parameter int NumStations = 6,
  parameter int NumSensors  = 6,
  parameter int CountBits   = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input word channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic                         event_is_even_i,
  input  logic [2:0]                   station_i,
  input  logic [2:0]                   sensor_i,
  input  logic [9:0]                   row_i,
  input  logic [7:0]                   adc_i,
  // result word channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [23:0]                  hit_count_o,
  output logic [31:0]                  adc_sum_o,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [shdcm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [shdcm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import shdcm_pkg::*;

  localparam int NumPairs = NumStations * NumSensors;
  localparam int Depth    = NumPairs * NumStrips;
  localparam int PairW    = (NumPairs > 1) ? $clog2(NumPairs) : 1;
  localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int EntW     = SUM_W + CountBits;
  localparam int CntExtW  = (CountBits > OUT_CNT_W) ? CountBits : OUT_CNT_W;
  localparam int NCmpW    = (CountBits > THR_W) ? CountBits : THR_W;

  localparam logic [3:0]  StationLim = 4'(NumStations);
  localparam logic [3:0]  SensorLim  = 4'(NumSensors);
  localparam logic [10:0] RowLim     = 11'(NumStrips);

  // Control sequencer. CLEAR sweeps the memory after reset; HIT writes back
  // the read-modified entry; QRD sees the read data of a query; HOT waits on
  // the test unit; EMIT hands the result to the output register.
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_HIT   = 6'b000100,
    ST_QRD   = 6'b001000,
    ST_HOT   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [AddrW-1:0]      clr_addr_q, clr_addr_d;
  logic [NumPairs-1:0]   touched_q, touched_d;

  // configuration
  logic                  skip_even_q;
  logic [THR_W-1:0]      dead_thr_q;
  logic [PED_W-1:0]      ped_x2_q;

  // held word / result staging
  logic [AddrW-1:0]      addr_q, addr_d;
  logic [ADC_W-1:0]      adc_q, adc_d;
  status_e               res_status_q, res_status_d;
  logic [OUT_CNT_W-1:0]  res_count_q, res_count_d;
  logic [SUM_W-1:0]      res_sum_q, res_sum_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [OUT_CNT_W-1:0]  out_count_q, out_count_d;
  logic [SUM_W-1:0]      out_sum_q, out_sum_d;
  logic                  out_load;

  // strip memory: {sum, count} per cell
  logic [EntW-1:0]       strip_mem [Depth];
  logic                  mem_re, mem_we;
  logic [AddrW-1:0]      mem_addr;
  logic [EntW-1:0]       mem_wdata, mem_rdata_q;

  // hot test unit
  logic                  hot_start, hot_busy;
  hot_rsp_t              hot_rsp;

  // decode of the incoming word
  logic                  in_accept, pair_ok, row_ok, skip_hit;
  logic [PairW-1:0]      pair_idx;
  logic [AddrW-1:0]      cell_addr;

  // read-modify-write datapath
  logic [CountBits-1:0]  rd_cnt, cnt_inc;
  logic [SUM_W-1:0]      rd_sum, sum_inc;
  logic [SUM_W:0]        sum_ext;
  logic [CntExtW-1:0]    cnt_ext;
  logic [OUT_CNT_W-1:0]  cnt_clamped;
  logic                  is_dead;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign pair_ok   = ({1'b0, station_i} < StationLim) && ({1'b0, sensor_i} < SensorLim);
  assign row_ok    = ({1'b0, row_i} < RowLim);
  assign skip_hit  = skip_even_q && event_is_even_i;
  assign pair_idx  = PairW'(station_i * NumSensors + sensor_i);
  assign cell_addr = AddrW'(pair_idx * NumStrips + row_i);

  assign rd_cnt  = mem_rdata_q[CountBits-1:0];
  assign rd_sum  = mem_rdata_q[EntW-1:CountBits];
  // both saturate
  assign cnt_inc = (&rd_cnt) ? rd_cnt : rd_cnt + CountBits'(1);
  assign sum_ext = {1'b0, rd_sum} + (SUM_W + 1)'(adc_q);
  assign sum_inc = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  assign cnt_ext     = CntExtW'(rd_cnt);
  assign cnt_clamped = (cnt_ext > CntExtW'({OUT_CNT_W{1'b1}})) ? '1
                                                              : cnt_ext[OUT_CNT_W-1:0];
  // zero threshold: nothing is dead
  assign is_dead     = NCmpW'(rd_cnt) < NCmpW'(dead_thr_q);

  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    touched_d    = touched_q;
    addr_d       = addr_q;
    adc_d        = adc_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    res_sum_d    = res_sum_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = addr_q;
    mem_wdata    = {sum_inc, cnt_inc};
    hot_start    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_addr   = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_addr = cell_addr;
        if (in_accept) begin
          addr_d = cell_addr;
          adc_d  = adc_i;
          if (op_i == OP_HIT) begin
            // skipped events and bad sensors leave everything alone;
            // a bad row still touches the sensor
            if (!skip_hit && pair_ok) begin
              touched_d[pair_idx] = 1'b1;
              if (row_ok) begin
                mem_re  = 1'b1;
                state_d = ST_HIT;
              end
            end
          end else begin
            if (pair_ok && row_ok && touched_q[pair_idx]) begin
              mem_re  = 1'b1;
              state_d = ST_QRD;
            end else begin
              res_status_d = STATUS_NO_DATA;
              res_count_d  = '0;
              res_sum_d    = '0;
              state_d      = ST_EMIT;
            end
          end
        end
      end
      ST_HIT: begin
        mem_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_QRD: begin
        res_count_d = cnt_clamped;
        res_sum_d   = rd_sum;
        if (is_dead) begin
          res_status_d = STATUS_DEAD;
          state_d      = ST_EMIT;
        end else begin
          hot_start = 1'b1;
          state_d   = ST_HOT;
        end
      end
      ST_HOT: begin
        if (hot_rsp.done) begin
          res_status_d = hot_rsp.hot ? STATUS_HOT : STATUS_NORMAL;
          state_d      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register: result waits here while the next word is taken
  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_sum_d    = out_sum_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_count_d  = res_count_q;
      out_sum_d    = res_sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      touched_q   <= '0;
      out_valid_q <= 1'b0;
      skip_even_q <= 1'b0;
      dead_thr_q  <= THR_W'(5);
      ped_x2_q    <= PED_W'(7);
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      touched_q   <= touched_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SKIP_EVEN: skip_even_q <= cfg_data_i[0];
          CFG_DEAD_THR:  dead_thr_q  <= cfg_data_i;
          CFG_PED_X2:    ped_x2_q    <= cfg_data_i;
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    adc_q        <= adc_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    res_sum_q    <= res_sum_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_sum_q    <= out_sum_d;
  end

  // single-port strip memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      strip_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= strip_mem[mem_addr];
    end
  end

  shdcm_hot_test #(
    .CountBits(CountBits)
  ) u_hot_test (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hot_start),
    .n_i    (rd_cnt),
    .s_i    (rd_sum),
    .p_i    (ped_x2_q),
    .busy_o (hot_busy),
    .rsp_o  (hot_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign hit_count_o = out_count_q;
  assign adc_sum_o   = out_sum_q;

  `ASSERT_NEVER(a_mem_one_port, clk_i, rst_ni, mem_re && mem_we, "memory read and write together")
  `ASSERT_IMPLY(a_wb_after_read, clk_i, rst_ni, state_q == ST_HIT, $past(mem_re),
                "write back without a read")
  `ASSERT_IMPLY(a_hot_free, clk_i, rst_ni, hot_start, !hot_busy, "hot test started while busy")
  `ASSERT_IMPLY(a_out_no_clobber, clk_i, rst_ni, out_load, !out_valid_q || !out_stall_i,
                "held result overwritten")

endmodule

FILE: tb/tb_strip_hot_dead_channel_monitor_core.sv
// ---------------------------------------------------------------------------
// tb_strip_hot_dead_channel_monitor_core
// Self-checking bench for the strip hot/dead monitor: a queue-fed driver,
// a clocked monitor that scores each report against a local strip tally,
// random idling on both sides, and several register settings per run.
// ---------------------------------------------------------------------------
module tb_strip_hot_dead_channel_monitor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import shdcm_pkg::*;

  localparam int STRIPS      = 639;
  localparam int STATIONS    = 6;
  localparam int SENSORS     = 6;
  localparam int PAIRS       = STATIONS * SENSORS;
  localparam int CELLS       = PAIRS * STRIPS;
  localparam int IDLE_PCT    = 17;
  localparam int SETTLE_CYC  = 100;      // longest query plus margin
  localparam int HOLD_CYC    = 400;      // long receiver hold-off
  localparam int CYCLE_LIMIT = 3000000;  // hang guard

  // one input word, field for field
  typedef struct packed {
    logic       op;
    logic       even;
    logic [2:0] station;
    logic [2:0] sensor;
    logic [9:0] row;
    logic [7:0] adc;
  } strip_word_t;

  // one report word
  typedef struct packed {
    status_e     status;
    logic [23:0] hit_count;
    logic [31:0] adc_sum;
  } strip_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i;
  logic        event_is_even_i;
  logic [2:0]  station_i;
  logic [2:0]  sensor_i;
  logic [9:0]  row_i;
  logic [7:0]  adc_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [23:0] hit_count_o;
  logic [31:0] adc_sum_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  strip_word_t   cur_word = '0;     // word on the input port
  strip_word_t   words_to_send[$];  // backlog for the driver
  strip_report_t reports_due[$];    // expected reports, oldest first

  // local copy of the strip tallies and the registers
  bit [23:0] strip_hits[CELLS];
  bit [31:0] strip_sum[CELLS];
  bit        sensor_seen[PAIRS];
  bit        cfg_skip_even = 1'b0;
  bit [7:0]  cfg_dead_thr  = 8'd5;
  bit [7:0]  cfg_ped_x2    = 8'd7;

  bit word_taken  = 1'b0;  // set at the edge a word is accepted
  bit steady      = 1'b0;  // no idling on either side while set
  bit hold_req    = 1'b0;
  bit hold_served = 1'b0;
  int hold_left   = 0;
  int mismatches  = 0;
  int cycles      = 0;

  assign op_i            = cur_word.op;
  assign event_is_even_i = cur_word.even;
  assign station_i       = cur_word.station;
  assign sensor_i        = cur_word.sensor;
  assign row_i           = cur_word.row;
  assign adc_i           = cur_word.adc;

  strip_hot_dead_channel_monitor_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .event_is_even_i (event_is_even_i),
    .station_i       (station_i),
    .sensor_i        (sensor_i),
    .row_i           (row_i),
    .adc_i           (adc_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .hit_count_o     (hit_count_o),
    .adc_sum_o       (adc_sum_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #4ns clk_i = ~clk_i;

  // Exact integer hot test. n = count, s = sum, p = pedestal x2.
  // Low counts: d = 2s - p*n must be positive and d*d*n > 36*s*s.
  // High counts: 94*s > 50*p*n. 128 bits cover every product here.
  function automatic bit strip_is_hot(bit [23:0] n, bit [31:0] s, bit [7:0] p);
    bit [127:0] twice_s, pn, d, lhs, rhs;
    twice_s = 128'(s) << 1;
    pn      = 128'(p) * 128'(n);
    if (n <= 24'(SMALL_N_MAX)) begin
      if (twice_s <= pn) return 1'b0;
      d   = twice_s - pn;
      lhs = d * d * 128'(n);
      rhs = 128'(s) * 128'(s) * 128'(36);
      return lhs > rhs;
    end
    return 128'(s) * 128'(HOT_S_MUL) > pn * 128'(HOT_PN_MUL);
  endfunction

  // Applies one accepted word to the local tallies; a query queues the
  // report the block must return for it.
  function automatic void apply_strip_word(strip_word_t w);
    bit            in_map;
    int            pair, strip_idx;
    bit [32:0]     sum_ext;
    strip_report_t rep;
    in_map    = (int'(w.station) < STATIONS) && (int'(w.sensor) < SENSORS);
    pair      = in_map ? int'(w.station) * SENSORS + int'(w.sensor) : 0;
    strip_idx = pair * STRIPS + int'(w.row);
    if (w.op == OP_HIT) begin
      // skipped events do not even touch the sensor
      if ((cfg_skip_even && w.even) || !in_map) return;
      sensor_seen[pair] = 1'b1;
      // out-of-range row: sensor touched, no strip changes
      if (int'(w.row) < STRIPS) begin
        if (strip_hits[strip_idx] != '1)
          strip_hits[strip_idx] = strip_hits[strip_idx] + 24'd1;
        sum_ext = {1'b0, strip_sum[strip_idx]} + 33'(w.adc);
        strip_sum[strip_idx] = sum_ext[32] ? '1 : sum_ext[31:0];
      end
      return;
    end
    rep.status    = STATUS_NO_DATA;
    rep.hit_count = '0;
    rep.adc_sum   = '0;
    if (in_map && int'(w.row) < STRIPS && sensor_seen[pair]) begin
      if (strip_hits[strip_idx] < 24'(cfg_dead_thr))
        rep.status = STATUS_DEAD;
      else if (strip_is_hot(strip_hits[strip_idx], strip_sum[strip_idx], cfg_ped_x2))
        rep.status = STATUS_HOT;
      else
        rep.status = STATUS_NORMAL;
      rep.hit_count = strip_hits[strip_idx];
      rep.adc_sum   = strip_sum[strip_idx];
    end
    reports_due.insert(reports_due.size(), rep);
  endfunction

  function automatic void queue_hit(bit [2:0] st, bit [2:0] se, bit [9:0] row,
                                    bit [7:0] adc, bit even);
    strip_word_t w;
    w.op = OP_HIT; w.even = even; w.station = st; w.sensor = se;
    w.row = row; w.adc = adc;
    words_to_send.insert(words_to_send.size(), w);
  endfunction

  // event flag and ADC of a query are don't-care, so randomize them
  function automatic void queue_query(bit [2:0] st, bit [2:0] se, bit [9:0] row);
    strip_word_t w;
    w.op = OP_QUERY; w.even = 1'($urandom); w.station = st; w.sensor = se;
    w.row = row; w.adc = 8'($urandom);
    words_to_send.insert(words_to_send.size(), w);
  endfunction

  // Random traffic: mostly hits and queries on a few focus strips, so that
  // counts climb through the dead/hot/normal bands, plus fully random noise
  // (stations, sensors and rows out of range included).
  function automatic void queue_random_phase(int count);
    bit [2:0] fst[6];
    bit [2:0] fse[6];
    bit [9:0] frow[6];
    int       r, pick, a;
    for (int k = 0; k < 6; k++) begin
      fst[k]  = 3'($urandom_range(0, STATIONS - 1));
      fse[k]  = 3'($urandom_range(0, SENSORS - 1));
      frow[k] = (k == 0) ? 10'(STRIPS - 1) : 10'($urandom_range(0, STRIPS - 1));
    end
    for (int i = 0; i < count; i++) begin
      r    = $urandom_range(0, 99);
      pick = $urandom_range(0, 5);
      if (r < 55) begin
        // half near the pedestal (normal side), half anywhere
        if ($urandom_range(0, 1) == 1) begin
          a = int'(cfg_ped_x2 >> 1) + int'($urandom_range(0, 3)) - 1;
          if (a < 0) a = 0;
          if (a > 255) a = 255;
        end else begin
          a = $urandom_range(0, 255);
        end
        queue_hit(fst[pick], fse[pick], frow[pick], 8'(a), 1'($urandom));
      end else if (r < 80) begin
        queue_query(fst[pick], fse[pick], frow[pick]);
      end else if (r < 90) begin
        queue_hit(3'($urandom), 3'($urandom), 10'($urandom), 8'($urandom),
                  1'($urandom));
      end else begin
        queue_query(3'($urandom), 3'($urandom), 10'($urandom));
      end
    end
  endfunction

  // register write; the local copy follows at the handshake
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SKIP_EVEN: cfg_skip_even = data[0];
      CFG_DEAD_THR:  cfg_dead_thr  = data;
      CFG_PED_X2:    cfg_ped_x2    = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(bit skip, bit [7:0] thr, bit [7:0] ped);
    write_reg(CFG_SKIP_EVEN, {7'd0, skip});
    write_reg(CFG_DEAD_THR, thr);
    write_reg(CFG_PED_X2, ped);
  endtask

  // Wait until the backlog is sent and every report is in. Hits return
  // nothing, so also let a full query latency pass before going on.
  task automatic drain();
    while (words_to_send.size() != 0 || in_valid_i || reports_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Driver: loads the next word once the current one is taken; a stalled
  // word stays put. Random idle cycles, none while steady.
  always @(negedge clk_i) begin : drive
    if (!in_valid_i || word_taken) begin
      word_taken = 1'b0;
      if (words_to_send.size() != 0 &&
          (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        cur_word   <= words_to_send.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request, counted here
  always @(negedge clk_i) begin : receive
    if (hold_req && !hold_served) begin
      hold_left   = HOLD_CYC;
      hold_served = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Monitor: handshakes sampled at the rising edge
  always @(posedge clk_i) begin : monitor
    strip_report_t exp_rep;
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_strip_word(cur_word);
        word_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (reports_due.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("report with none expected: status %0d count %0d sum %0d",
                     status_o, hit_count_o, adc_sum_o);
        end else begin
          exp_rep = reports_due.pop_front();
          if (status_o !== exp_rep.status || hit_count_o !== exp_rep.hit_count ||
              adc_sum_o !== exp_rep.adc_sum) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("bad report: status %0d/%0d count %0d/%0d sum %0d/%0d (exp/act)",
                       exp_rep.status, status_o, exp_rep.hit_count, hit_count_o,
                       exp_rep.adc_sum, adc_sum_o);
          end
        end
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed: corners and each special case, threshold 4 ---
    // (the block is still clearing its memory; the driver just waits)
    set_regs(1'b0, 8'd4, 8'd7);
    queue_query(3'd0, 3'd0, 10'd0);                // untouched sensor
    queue_hit(3'd5, 3'd5, 10'(STRIPS - 1), 8'd255, 1'b1);
    queue_query(3'd5, 3'd5, 10'(STRIPS - 1));      // one hit: dead
    queue_hit(3'd0, 3'd0, 10'd1023, 8'd0, 1'b0);   // bad row still touches
    queue_query(3'd0, 3'd0, 10'd0);                // touched, zero count
    queue_query(3'd0, 3'd0, 10'd1023);             // bad row: no data
    queue_hit(3'd6, 3'd0, 10'd0, 8'd9, 1'b0);      // bad station, ignored
    queue_hit(3'd7, 3'd7, 10'd1023, 8'd9, 1'b1);   // all out of range
    queue_query(3'd6, 3'd0, 10'd0);
    queue_query(3'd0, 3'd7, 10'd0);
    for (int k = 0; k < 10; k++)                   // ten full-scale hits: hot
      queue_hit(3'd2, 3'd3, 10'd100, 8'd255, 1'(k));
    queue_query(3'd2, 3'd3, 10'd100);
    queue_hit(3'd1, 3'd1, 10'd1, 8'd4, 1'b0);      // just above pedestal
    queue_hit(3'd1, 3'd1, 10'd1, 8'd3, 1'b1);
    queue_hit(3'd1, 3'd1, 10'd1, 8'd4, 1'b0);
    queue_hit(3'd1, 3'd1, 10'd1, 8'd4, 1'b1);
    queue_query(3'd1, 3'd1, 10'd1);                // normal
    drain();

    // --- random, low extremes: even events skipped, nothing is dead ---
    set_regs(1'b1, 8'd0, 8'd0);
    queue_random_phase(100);
    drain();

    // --- random, high extremes ---
    set_regs(1'b0, 8'd255, 8'd255);
    queue_random_phase(100);
    drain();

    // --- random, mid settings, no idling anywhere ---
    set_regs(1'b0, 8'($urandom_range(1, 20)), 8'($urandom_range(1, 254)));
    steady = 1'b1;
    queue_random_phase(100);
    drain();
    steady = 1'b0;

    // --- random with a long receiver hold-off: reports back up and the
    //     input stalls while the driver keeps offering words ---
    set_regs(1'b1, 8'd8, 8'd12);
    queue_random_phase(100);
    hold_req = 1'b1;
    drain();

    // --- random, default-like settings ---
    set_regs(1'b0, 8'd5, 8'd7);
    queue_random_phase(100);
    drain();

    // --- one strip hammered across the dead threshold of 255 ---
    set_regs(1'b0, 8'd255, 8'd255);
    for (int k = 1; k <= 260; k++) begin
      queue_hit(3'd3, 3'd2, 10'd17, 8'($urandom_range(100, 255)), 1'($urandom));
      if (k inside {254, 255, 256, 260})
        queue_query(3'd3, 3'd2, 10'd17);
    end
    drain();

    if (mismatches == 0 && reports_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
